// ===== design/piecewise_linear_interpolator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear interpolator
// Concurrent checks clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_MACROS_SVH

// prop must hold at every edge out of reset
`define PLI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// cond must never be true out of reset
`define PLI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== design/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg
// Shared widths, request codes and defaults for the interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pli_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned IDX_W          = 4;
  localparam int unsigned CNT_W          = 5;
  localparam int unsigned MAX_POINTS_DEF = 16;
  localparam int unsigned MIN_POINTS     = 2;
  localparam int unsigned DIV_STEPS      = DATA_W;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

// ===== design/pli_ram.sv =====
// ----------------------------------------------------------------------------
// pli_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pli_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pli_div.sv =====
// ----------------------------------------------------------------------------
// pli_div
// Restoring radix-2 divider, one quotient bit per cycle. The upper half of
// the dividend must be below the divisor, so the quotient fits DATA_W bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pli_div
  import pli_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2*DATA_W-1:0]   dividend_i,
  input  logic [DATA_W-1:0]     divisor_i,
  output logic                  done_o,
  output logic [DATA_W-1:0]     quotient_o
);

  localparam int unsigned SW = $clog2(DIV_STEPS);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SW-1:0]     cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] lo_q, lo_d;
  logic [DATA_W+1:0] diff;
  logic              ge;

  assign diff = {1'b0, rem_q, lo_q[DATA_W-1]} - {2'b00, divisor_i};
  assign ge   = ~diff[DATA_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i[2*DATA_W-1:DATA_W];
      lo_d   = dividend_i[DATA_W-1:0];
    end else if (busy_q) begin
      rem_d = ge ? diff[DATA_W-1:0] : {rem_q[DATA_W-2:0], lo_q[DATA_W-1]};
      lo_d  = {lo_q[DATA_W-2:0], ge};
      cnt_d = cnt_q + SW'(1);
      if (cnt_q == SW'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = lo_q;

endmodule

// ===== design/piecewise_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Flow: a load request writes its table entry; an interpolating query runs a RAM scan
//   over the points in use, then multiply and divide steps to the result register;
//   a query at a knot or outside the span stops after the scan, one with fewer than two points skips it.
// Throughput: one request at a time; the next is taken once the result is staged.
// Reset: async low clears control and point_count; the table holds garbage until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "piecewise_linear_interpolator_macros.svh"

module piecewise_linear_interpolator
  import pli_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CNT_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     req_type_i,
  input  logic [IDX_W-1:0]         entry_index_i,
  input  logic signed [DATA_W-1:0] entry_x_i,
  input  logic signed [DATA_W-1:0] entry_y_i,
  input  logic signed [DATA_W-1:0] query_x_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] value_o,
  output logic                     in_range_o
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DLD  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] point_count_q;
  logic [CW-1:0]    n_w;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             have_l_q, have_l_d, have_r_q, have_r_d;
  logic             out_valid_q, out_valid_d;

  logic signed [DATA_W-1:0] qx_q, qx_d;
  logic signed [DATA_W-1:0] xl_q, xl_d, yl_q, yl_d;
  logic signed [DATA_W-1:0] xr_q, xr_d, yr_q, yr_d;
  logic [DATA_W-1:0]        mag_q, mag_d, dq_q, dq_d, dx_q, dx_d;
  logic                     neg_q, neg_d;
  logic [2*DATA_W-1:0]      prod_q, prod_d;
  logic signed [DATA_W-1:0] res_val_q, res_val_d;
  logic                     res_rng_q, res_rng_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic                     in_range_q, in_range_d;

  logic                     accept;
  logic                     ram_we;
  logic [2*DATA_W-1:0]      ram_rdata;
  logic signed [DATA_W-1:0] rd_x, rd_y;
  logic                     upd_l, upd_r;
  logic signed [DATA_W:0]   dy;
  logic                     div_start, div_done;
  logic [DATA_W-1:0]        quo;
  logic signed [DATA_W+1:0] sum;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign ram_we     = accept & (req_type_i == REQ_LOAD) & (32'(entry_index_i) < MAX_POINTS);

  always_comb begin
    if (32'(point_count_q) > MAX_POINTS) begin
      n_w = CW'(MAX_POINTS);
    end else begin
      n_w = CW'(point_count_q);
    end
  end

  pli_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({entry_x_i, entry_y_i}),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_x = ram_rdata[2*DATA_W-1:DATA_W];
  assign rd_y = ram_rdata[DATA_W-1:0];

  // strict compares keep the lowest index among equal abscissas
  assign upd_l = (rd_x <= qx_q) && (!have_l_q || (rd_x > xl_q));
  assign upd_r = (rd_x >= qx_q) && (!have_r_q || (rd_x < xr_q));

  assign dy        = {yr_q[DATA_W-1], yr_q} - {yl_q[DATA_W-1], yl_q};
  assign prod_d    = mag_q * dq_q;
  assign div_start = (state_q == ST_DLD);

  pli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (dx_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign sum = neg_q ? ({{2{yl_q[DATA_W-1]}}, yl_q} - {2'b00, quo})
                     : ({{2{yl_q[DATA_W-1]}}, yl_q} + {2'b00, quo});

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    have_l_d    = have_l_q;
    have_r_d    = have_r_q;
    out_valid_d = out_valid_q;
    qx_d        = qx_q;
    xl_d        = xl_q;
    yl_d        = yl_q;
    xr_d        = xr_q;
    yr_d        = yr_q;
    mag_d       = mag_q;
    dq_d        = dq_q;
    dx_d        = dx_q;
    neg_d       = neg_q;
    res_val_d   = res_val_q;
    res_rng_d   = res_rng_q;
    value_d     = value_q;
    in_range_d  = in_range_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == REQ_QUERY)) begin
          qx_d      = query_x_i;
          have_l_d  = 1'b0;
          have_r_d  = 1'b0;
          cnt_d     = '0;
          res_val_d = '0;
          res_rng_d = 1'b0;
          if (n_w < CW'(MIN_POINTS)) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_q != '0) begin
          if (upd_l) begin
            xl_d     = rd_x;
            yl_d     = rd_y;
            have_l_d = 1'b1;
          end
          if (upd_r) begin
            xr_d     = rd_x;
            yr_d     = rd_y;
            have_r_d = 1'b1;
          end
        end
        if (cnt_q == n_w) begin
          state_d = ST_EVAL;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_EVAL: begin
        neg_d = dy[DATA_W];
        mag_d = dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
        dq_d  = DATA_W'(qx_q - xl_q);
        dx_d  = DATA_W'(xr_q - xl_q);
        if (!have_l_q || !have_r_q) begin
          res_val_d = '0;
          res_rng_d = 1'b0;
          state_d   = ST_FIN;
        end else if (xl_q == xr_q) begin
          res_val_d = yl_q;
          res_rng_d = 1'b1;
          state_d   = ST_FIN;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DLD;
      end
      ST_DLD: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_rng_d = 1'b1;
          if (sum > (DATA_W+2)'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
            res_val_d = {1'b0, {(DATA_W-1){1'b1}}};
          end else if (sum < -(DATA_W+2)'(signed'({1'b0, 1'b1, {(DATA_W-1){1'b0}}}))) begin
            res_val_d = {1'b1, {(DATA_W-1){1'b0}}};
          end else begin
            res_val_d = sum[DATA_W-1:0];
          end
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          value_d     = res_val_q;
          in_range_d  = res_rng_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      point_count_q <= '0;
      cnt_q         <= '0;
      have_l_q      <= 1'b0;
      have_r_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      have_l_q      <= have_l_d;
      have_r_q      <= have_r_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        point_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q       <= qx_d;
    xl_q       <= xl_d;
    yl_q       <= yl_d;
    xr_q       <= xr_d;
    yr_q       <= yr_d;
    mag_q      <= mag_d;
    dq_q       <= dq_d;
    dx_q       <= dx_d;
    neg_q      <= neg_d;
    prod_q     <= prod_d;
    res_val_q  <= res_val_d;
    res_rng_q  <= res_rng_d;
    value_q    <= value_d;
    in_range_q <= in_range_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign in_range_o  = in_range_q;

  `PLI_ASSERT(a_div_bound, clk_i, rst_ni, div_start |-> (prod_q[2*DATA_W-1:DATA_W] < dx_q), "quotient overflow")
  `PLI_ASSERT_NEVER(a_done_state, clk_i, rst_ni, div_done && (state_q != ST_DIV), "stray divide done")
  `PLI_ASSERT(a_span, clk_i, rst_ni, (state_q == ST_EVAL) && have_l_q && have_r_q |-> (xl_q <= qx_q) && (qx_q <= xr_q), "bracket wrong")
  `PLI_ASSERT(a_scan_cnt, clk_i, rst_ni, (state_q == ST_SCAN) |-> (cnt_q <= n_w), "scan overrun")
  `PLI_ASSERT(a_zero_out, clk_i, rst_ni, out_valid_q && !in_range_q |-> (value_q == '0), "nonzero out of range")

endmodule
